// ----- rtl/cbf_pkg.sv -----
// Shared request codes, field widths and register map of the counting Bloom filter.
package cbf_pkg;

    // Request codes carried in req_type.
    typedef enum logic [1:0] {
        REQ_QUERY  = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_type_t;

    // Field widths.
    localparam int REQ_W   = 2;
    localparam int HASH_W  = 64;
    localparam int HALF_W  = 32;
    localparam int HIT_W   = 8;
    localparam int SIZE_W  = 13;
    localparam int LIMIT_W = 8;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_ACTIVE_SIZE = 1'b0;
    localparam logic REG_MAX_COUNT   = 1'b1;

    // Register reset values.
    localparam logic [SIZE_W-1:0]  ACTIVE_SIZE_RST = 13'd4096;
    localparam logic [LIMIT_W-1:0] MAX_COUNT_RST   = 8'd254;

endpackage

// ----- rtl/counting_bloom_filter.sv -----
// Top level of the counting Bloom filter: configuration registers, front end, queue, back end.
// Start to done: the two-bit-per-cycle index modulo dominates, then the queue and the back-end update.
// The front end takes a new request only after its modulo unit is done and the last one is queued.
// A clear request keeps the back end busy sweeping every counter to zero.
// After reset, busy stays high while the counter memory is swept to zero.
// Results appear for one cycle on done; the receiver cannot stall them.
module counting_bloom_filter #(
    parameter int NUM_COUNTERS = 4096,
    parameter int COUNTER_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [cbf_pkg::REQ_W-1:0]          req_type,
    input  logic [cbf_pkg::HASH_W-1:0]         key_hash,
    output logic                               done,
    output logic                               accepted,
    output logic                               should_not_add,
    output logic [cbf_pkg::HIT_W-1:0]          hit_count,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cbf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cbf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cbf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int IDX_W = $clog2(NUM_COUNTERS);
    localparam int SZ_W  = $clog2(NUM_COUNTERS + 1);
    localparam int Q_W   = cbf_pkg::REQ_W + 2 * IDX_W;

    logic [cbf_pkg::SIZE_W-1:0]  active_size_reg;
    logic [cbf_pkg::LIMIT_W-1:0] max_count_reg;
    logic [SZ_W-1:0]             used_size;
    logic                        cfg_wr;
    logic                        accept;
    logic                        front_busy;
    logic                        init_busy;

    logic                        fq_valid;
    logic                        fq_ready;
    logic [cbf_pkg::REQ_W-1:0]   fq_req;
    logic [IDX_W-1:0]            fq_idx_a;
    logic [IDX_W-1:0]            fq_idx_b;
    logic                        qb_valid;
    logic                        qb_ready;
    logic [Q_W-1:0]              qb_data;

    // Configuration writes; registers are word aligned, so paddr[1:0] is not decoded.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= cbf_pkg::ACTIVE_SIZE_RST;
            max_count_reg   <= cbf_pkg::MAX_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == cbf_pkg::REG_ACTIVE_SIZE)
            begin
                active_size_reg <= pwdata[cbf_pkg::SIZE_W-1:0];
            end
            else
            begin
                max_count_reg <= pwdata[cbf_pkg::LIMIT_W-1:0];
            end
        end
    end

    // Register read-back.
    always_comb
    begin
        if (paddr[2] == cbf_pkg::REG_MAX_COUNT)
        begin
            prdata = cbf_pkg::APB_DATA_W'(max_count_reg);
        end
        else
        begin
            prdata = cbf_pkg::APB_DATA_W'(active_size_reg);
        end
    end

    // Modulus in use: the full store when the configured size is zero or too large.
    always_comb
    begin
        if ((active_size_reg == '0) || (32'(active_size_reg) > 32'(NUM_COUNTERS)))
        begin
            used_size = SZ_W'(NUM_COUNTERS);
        end
        else
        begin
            used_size = SZ_W'(active_size_reg);
        end
    end

    // Request acceptance.
    assign busy   = front_busy || init_busy;
    assign accept = start && !busy;

    cbf_front #(
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (req_type),
        .key_hash  (key_hash),
        .used_size (used_size),
        .busy      (front_busy),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_req     (fq_req),
        .q_idx_a   (fq_idx_a),
        .q_idx_b   (fq_idx_b)
    );

    cbf_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({fq_req, fq_idx_a, fq_idx_b}),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    cbf_back #(
        .NUM_COUNTERS (NUM_COUNTERS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (qb_valid),
        .q_ready        (qb_ready),
        .q_req          (qb_data[Q_W-1 -: cbf_pkg::REQ_W]),
        .q_idx_a        (qb_data[2*IDX_W-1 -: IDX_W]),
        .q_idx_b        (qb_data[IDX_W-1:0]),
        .max_count      (max_count_reg),
        .init_busy      (init_busy),
        .done           (done),
        .accepted       (accepted),
        .should_not_add (should_not_add),
        .hit_count      (hit_count)
    );

endmodule

// ----- rtl/cbf_front.sv -----
// Front end: takes a request and reduces both hash halves modulo the size in use.
module cbf_front #(
    parameter int NUM_COUNTERS = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  logic [cbf_pkg::REQ_W-1:0]              req_type,
    input  logic [cbf_pkg::HASH_W-1:0]             key_hash,
    input  logic [$clog2(NUM_COUNTERS+1)-1:0]      used_size,
    output logic                                   busy,
    output logic                                   q_valid,
    input  logic                                   q_ready,
    output logic [cbf_pkg::REQ_W-1:0]              q_req,
    output logic [$clog2(NUM_COUNTERS)-1:0]        q_idx_a,
    output logic [$clog2(NUM_COUNTERS)-1:0]        q_idx_b
);

    localparam int IDX_W     = $clog2(NUM_COUNTERS);
    localparam int SZ_W      = $clog2(NUM_COUNTERS + 1);
    localparam int STEP_BITS = 2;
    localparam int NUM_STEPS = cbf_pkg::HALF_W / STEP_BITS;
    localparam int CNT_W     = $clog2(NUM_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH
    } state_t;

    state_t                      state_reg;
    logic [cbf_pkg::REQ_W-1:0]   req_reg;
    logic [cbf_pkg::HALF_W-1:0]  hi_reg;
    logic [cbf_pkg::HALF_W-1:0]  lo_reg;
    logic [SZ_W-1:0]             sz_reg;
    logic [SZ_W-1:0]             rem_hi_reg;
    logic [SZ_W-1:0]             rem_lo_reg;
    logic [CNT_W-1:0]            step_reg;
    logic [SZ_W-1:0]             rem_hi_next;
    logic [SZ_W-1:0]             rem_lo_next;

    // One restoring step: shift in a dividend bit and subtract the modulus if it fits.
    function automatic logic [SZ_W-1:0] mod_step(
        input logic [SZ_W-1:0] rem,
        input logic            din,
        input logic [SZ_W-1:0] dvs
    );
        logic [SZ_W:0] t;
        t = {rem, din};
        if (t >= {1'b0, dvs})
        begin
            t = t - {1'b0, dvs};
        end
        return t[SZ_W-1:0];
    endfunction

    // Both remainders advance by two dividend bits per cycle.
    always_comb
    begin
        rem_hi_next = rem_hi_reg;
        rem_lo_next = rem_lo_reg;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            rem_hi_next = mod_step(rem_hi_next, hi_reg[cbf_pkg::HALF_W-1-k], sz_reg);
            rem_lo_next = mod_step(rem_lo_next, lo_reg[cbf_pkg::HALF_W-1-k], sz_reg);
        end
    end

    // Sequencer for one request: latch, divide, hand over to the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg    <= req_type;
                        hi_reg     <= key_hash[cbf_pkg::HASH_W-1:cbf_pkg::HALF_W];
                        lo_reg     <= key_hash[cbf_pkg::HALF_W-1:0];
                        sz_reg     <= used_size;
                        rem_hi_reg <= '0;
                        rem_lo_reg <= '0;
                        step_reg   <= '0;
                        state_reg  <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_hi_reg <= rem_hi_next;
                    rem_lo_reg <= rem_lo_next;
                    hi_reg     <= {hi_reg[cbf_pkg::HALF_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
                    lo_reg     <= {lo_reg[cbf_pkg::HALF_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
                    step_reg   <= step_reg + 1'b1;
                    if (step_reg == CNT_W'(NUM_STEPS - 1))
                    begin
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH:
                begin
                    if (q_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The remainder is below the size in use, so it fits the index width.
    assign busy    = (state_reg != ST_IDLE);
    assign q_valid = (state_reg == ST_PUSH);
    assign q_req   = req_reg;
    assign q_idx_a = rem_hi_reg[IDX_W-1:0];
    assign q_idx_b = rem_lo_reg[IDX_W-1:0];

endmodule

// ----- rtl/cbf_queue.sv -----
// Two-entry queue that carries classified requests from the front end to the back end.
module cbf_queue #(
    parameter int WIDTH = 26
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = data_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ----- rtl/cbf_back.sv -----
// Back end: counter memory, read-modify-write of two counters, clearing sweeps and results.
module cbf_back #(
    parameter int NUM_COUNTERS = 4096,
    parameter int COUNTER_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    output logic                               q_ready,
    input  logic [cbf_pkg::REQ_W-1:0]          q_req,
    input  logic [$clog2(NUM_COUNTERS)-1:0]    q_idx_a,
    input  logic [$clog2(NUM_COUNTERS)-1:0]    q_idx_b,
    input  logic [cbf_pkg::LIMIT_W-1:0]        max_count,
    output logic                               init_busy,
    output logic                               done,
    output logic                               accepted,
    output logic                               should_not_add,
    output logic [cbf_pkg::HIT_W-1:0]          hit_count
);

    localparam int IDX_W = $clog2(NUM_COUNTERS);
    localparam int CB    = COUNTER_BITS;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_WR2,
        ST_SWEEP
    } state_t;

    state_t                     state_reg;
    logic [cbf_pkg::REQ_W-1:0]  req_reg;
    logic [IDX_W-1:0]           idx_a_reg;
    logic [IDX_W-1:0]           idx_b_reg;
    logic [IDX_W-1:0]           clr_addr_reg;
    logic [CB-1:0]              rd_a_reg;
    logic [CB-1:0]              rd_b_reg;
    logic [CB-1:0]              new_b_reg;
    logic                       done_reg;
    logic                       accepted_reg;
    logic                       sna_reg;
    logic [cbf_pkg::HIT_W-1:0]  hit_reg;

    logic [CB-1:0]              mem [NUM_COUNTERS];

    logic                       both_nz;
    logic                       sna;
    logic [CB-1:0]              min_c;
    logic [cbf_pkg::HIT_W-1:0]  hit;
    logic [CB-1:0]              limit;
    logic                       do_add;
    logic                       do_rem;
    logic                       same_idx;
    logic                       acc;
    logic [CB:0]                sum_a;
    logic [CB:0]                sum_b;
    logic [CB-1:0]              new_a;
    logic [CB-1:0]              new_b;
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic [CB-1:0]              mem_wdata;
    logic                       last_addr;

    // Tests on the counters as read, before any update.
    always_comb
    begin
        limit    = CB'(max_count);
        both_nz  = (rd_a_reg != '0) && (rd_b_reg != '0);
        sna      = both_nz || (rd_a_reg >= limit) || (rd_b_reg >= limit);
        min_c    = (rd_a_reg < rd_b_reg) ? rd_a_reg : rd_b_reg;
        if (!both_nz)
        begin
            hit = '0;
        end
        else if (min_c > CB'(255))
        begin
            hit = '1;
        end
        else
        begin
            hit = min_c[cbf_pkg::HIT_W-1:0];
        end
        same_idx = (idx_a_reg == idx_b_reg);
        do_add   = (cbf_pkg::req_type_t'(req_reg) == cbf_pkg::REQ_ADD)
                   && (rd_a_reg < limit) && (rd_b_reg < limit);
        do_rem   = (cbf_pkg::req_type_t'(req_reg) == cbf_pkg::REQ_REMOVE) && both_nz;
        acc      = do_add || do_rem
                   || (cbf_pkg::req_type_t'(req_reg) == cbf_pkg::REQ_CLEAR);
    end

    // New counter values; equal indices move the single counter by two, saturating.
    always_comb
    begin
        sum_a = {1'b0, rd_a_reg} + (same_idx ? (CB+1)'(2) : (CB+1)'(1));
        sum_b = {1'b0, rd_b_reg} + (CB+1)'(1);
        if (do_add)
        begin
            new_a = sum_a[CB] ? '1 : sum_a[CB-1:0];
            new_b = sum_b[CB] ? '1 : sum_b[CB-1:0];
        end
        else if (same_idx)
        begin
            new_a = (rd_a_reg > CB'(2)) ? (rd_a_reg - CB'(2)) : '0;
            new_b = rd_b_reg - CB'(1);
        end
        else
        begin
            new_a = rd_a_reg - CB'(1);
            new_b = rd_b_reg - CB'(1);
        end
    end

    // Single write port shared by the sweeps and both counter updates.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        unique case (state_reg)
            ST_INIT, ST_SWEEP:
            begin
                mem_we = 1'b1;
            end
            ST_CALC:
            begin
                mem_we    = do_add || do_rem;
                mem_waddr = idx_a_reg;
                mem_wdata = new_a;
            end
            ST_WR2:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_b_reg;
                mem_wdata = new_b_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign last_addr = (clr_addr_reg == IDX_W'(NUM_COUNTERS - 1));

    // Counter memory with registered reads at both indices.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_READ)
        begin
            rd_a_reg <= mem[idx_a_reg];
            rd_b_reg <= mem[idx_b_reg];
        end
    end

    // Request sequencer and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_INIT, ST_SWEEP:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (last_addr)
                    begin
                        clr_addr_reg <= '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        req_reg   <= q_req;
                        idx_a_reg <= q_idx_a;
                        idx_b_reg <= q_idx_b;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    done_reg     <= 1'b1;
                    accepted_reg <= acc;
                    sna_reg      <= sna;
                    hit_reg      <= hit;
                    new_b_reg    <= new_b;
                    if (cbf_pkg::req_type_t'(req_reg) == cbf_pkg::REQ_CLEAR)
                    begin
                        state_reg <= ST_SWEEP;
                    end
                    else if ((do_add || do_rem) && !same_idx)
                    begin
                        state_reg <= ST_WR2;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_WR2:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign q_ready        = (state_reg == ST_IDLE);
    assign init_busy      = (state_reg == ST_INIT);
    assign done           = done_reg;
    assign accepted       = accepted_reg;
    assign should_not_add = sna_reg;
    assign hit_count      = hit_reg;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the counting Bloom filter: directed table, then randomised phases.
module testbench;

    import cbf_pkg::*;

    localparam int NUM_COUNTERS = 4096;
    localparam int COUNTER_BITS = 8;
    localparam longint unsigned COUNTER_MAX = (64'd1 << COUNTER_BITS) - 1;
    // Longest quiet stretch: reset sweep or clear sweep plus the settling wait before a write.
    localparam int QUIET_LIMIT = 4 * (2 * NUM_COUNTERS + 256);
    localparam int SETTLE_CYCLES = 64;
    localparam int POOL_SIZE = 6;
    localparam int DIRECTED_ROWS = 20;
    localparam int PHASE_COUNT = 10;

    typedef struct packed {
        logic              accepted;
        logic              should_not_add;
        logic [HIT_W-1:0]  hit_count;
    } filter_result_t;

    typedef struct packed {
        req_type_t         req;
        logic [HASH_W-1:0] hash;
        logic              typed;
        filter_result_t    result;
    } directed_row_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [LIMIT_W-1:0] limit;
        logic [15:0]        items;
        logic [7:0]         add_pct;
        logic [7:0]         remove_pct;
    } phase_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [REQ_W-1:0]       req_type = '0;
    logic [HASH_W-1:0]      key_hash = '0;
    logic                   done;
    logic                   accepted;
    logic                   should_not_add;
    logic [HIT_W-1:0]       hit_count;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Model of the counter store and shadow copies of the registers.
    logic [COUNTER_BITS-1:0] counter_model [NUM_COUNTERS];
    logic [SIZE_W-1:0]       size_shadow = ACTIVE_SIZE_RST;
    logic [LIMIT_W-1:0]      limit_shadow = MAX_COUNT_RST;

    filter_result_t expected_results [$];
    int             mismatch_count = 0;
    int             idle_pct = 0;
    bit             clear_pending = 1'b0;
    int unsigned    index_pool [POOL_SIZE];

    // Rows with typed = 1 carry a result that can be read straight off the specification.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{REQ_QUERY,  64'h0000_0000_0000_0000, 1'b1, '{1'b0, 1'b0, 8'd0}},
        '{REQ_ADD,    64'h0000_0000_0000_0000, 1'b1, '{1'b1, 1'b0, 8'd0}},
        '{REQ_QUERY,  64'h0000_0000_0000_0000, 1'b1, '{1'b0, 1'b1, 8'd2}},
        '{REQ_ADD,    64'h0000_0001_0000_0002, 1'b1, '{1'b1, 1'b0, 8'd0}},
        '{REQ_QUERY,  64'h0000_0001_0000_0002, 1'b1, '{1'b0, 1'b1, 8'd1}},
        '{REQ_REMOVE, 64'h0000_0001_0000_0002, 1'b1, '{1'b1, 1'b1, 8'd1}},
        '{REQ_REMOVE, 64'h0000_0001_0000_0002, 1'b1, '{1'b0, 1'b0, 8'd0}},
        '{REQ_REMOVE, 64'h0000_0000_0000_0000, 1'b1, '{1'b1, 1'b1, 8'd2}},
        '{REQ_ADD,    64'hffff_ffff_ffff_ffff, 1'b1, '{1'b1, 1'b0, 8'd0}},
        '{REQ_QUERY,  64'hffff_ffff_ffff_ffff, 1'b1, '{1'b0, 1'b1, 8'd2}},
        '{REQ_ADD,    64'hffff_ffff_0000_0000, 1'b1, '{1'b1, 1'b0, 8'd0}},
        '{REQ_QUERY,  64'hffff_ffff_0000_0000, 1'b1, '{1'b0, 1'b1, 8'd1}},
        '{REQ_CLEAR,  64'h0000_0000_0000_0000, 1'b1, '{1'b1, 1'b1, 8'd1}},
        '{REQ_QUERY,  64'hffff_ffff_0000_0000, 1'b1, '{1'b0, 1'b0, 8'd0}},
        '{REQ_ADD,    64'haaaa_aaaa_5555_5555, 1'b0, '{1'b0, 1'b0, 8'd0}},
        '{REQ_QUERY,  64'haaaa_aaaa_5555_5555, 1'b0, '{1'b0, 1'b0, 8'd0}},
        '{REQ_ADD,    64'h5555_5555_aaaa_aaaa, 1'b0, '{1'b0, 1'b0, 8'd0}},
        '{REQ_REMOVE, 64'haaaa_aaaa_5555_5555, 1'b0, '{1'b0, 1'b0, 8'd0}},
        '{REQ_ADD,    64'h0000_1000_0000_2000, 1'b1, '{1'b1, 1'b0, 8'd0}},
        '{REQ_REMOVE, 64'h0000_1000_0000_0000, 1'b1, '{1'b1, 1'b1, 8'd2}}
    };

    // Register settings per phase, extremes and out-of-range sizes among them.
    phase_t phases [PHASE_COUNT] = '{
        '{13'd1,    8'd255, 16'd200, 8'd85, 8'd8},
        '{13'd2,    8'd3,   16'd150, 8'd45, 8'd25},
        '{13'd0,    8'd254, 16'd120, 8'd45, 8'd25},
        '{13'd8191, 8'd10,  16'd120, 8'd50, 8'd20},
        '{13'd5,    8'd0,   16'd130, 8'd40, 8'd30},
        '{13'd4095, 8'd1,   16'd130, 8'd45, 8'd25},
        '{13'd13,   8'd128, 16'd150, 8'd55, 8'd20},
        '{13'd3,    8'd254, 16'd200, 8'd70, 8'd10},
        '{13'd16,   8'd7,   16'd150, 8'd45, 8'd25},
        '{13'd4096, 8'd255, 16'd180, 8'd50, 8'd20}
    };

    counting_bloom_filter #(
        .NUM_COUNTERS (NUM_COUNTERS),
        .COUNTER_BITS (COUNTER_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .key_hash       (key_hash),
        .done           (done),
        .accepted       (accepted),
        .should_not_add (should_not_add),
        .hit_count      (hit_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // An out-of-range size falls back to the full store.
    function automatic int unsigned modulus_in_use();
        if (size_shadow == 0 || size_shadow > NUM_COUNTERS)
            return NUM_COUNTERS;
        return size_shadow;
    endfunction

    function automatic logic [COUNTER_BITS-1:0] counter_plus(longint unsigned value,
                                                             longint unsigned step);
        longint unsigned sum;
        sum = value + step;
        return (sum > COUNTER_MAX) ? COUNTER_MAX[COUNTER_BITS-1:0] : sum[COUNTER_BITS-1:0];
    endfunction

    // Applies one request to the model store and returns the result it reports.
    function automatic filter_result_t filter_update(req_type_t req, logic [HASH_W-1:0] hash);
        int unsigned     modulus;
        int unsigned     idx_hi;
        int unsigned     idx_lo;
        longint unsigned cnt_hi;
        longint unsigned cnt_lo;
        longint unsigned low_val;
        bit              both;
        filter_result_t  r;
        modulus = modulus_in_use();
        idx_hi = hash[HASH_W-1:HALF_W] % modulus;
        idx_lo = hash[HALF_W-1:0] % modulus;
        cnt_hi = counter_model[idx_hi];
        cnt_lo = counter_model[idx_lo];
        both = (cnt_hi != 0) && (cnt_lo != 0);
        low_val = (cnt_hi < cnt_lo) ? cnt_hi : cnt_lo;
        r.accepted = 1'b0;
        r.should_not_add = both || cnt_hi >= limit_shadow || cnt_lo >= limit_shadow;
        r.hit_count = !both ? '0 : ((low_val > 255) ? 8'd255 : low_val[HIT_W-1:0]);
        case (req)
            REQ_ADD:
            begin
                if (cnt_hi < limit_shadow && cnt_lo < limit_shadow)
                begin
                    if (idx_hi == idx_lo)
                        counter_model[idx_hi] = counter_plus(cnt_hi, 2);
                    else
                    begin
                        counter_model[idx_hi] = counter_plus(cnt_hi, 1);
                        counter_model[idx_lo] = counter_plus(cnt_lo, 1);
                    end
                    r.accepted = 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                if (both)
                begin
                    if (idx_hi == idx_lo)
                        counter_model[idx_hi] = (cnt_hi > 2) ? cnt_hi - 2 : '0;
                    else
                    begin
                        counter_model[idx_hi] = cnt_hi - 1;
                        counter_model[idx_lo] = cnt_lo - 1;
                    end
                    r.accepted = 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                foreach (counter_model[i])
                    counter_model[i] = '0;
                r.accepted = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // A hash half that lands on the given index, with random multiples of the modulus above it.
    function automatic logic [HALF_W-1:0] half_for_index(int unsigned idx, int unsigned modulus);
        longint unsigned span;
        longint unsigned k;
        span = (64'hffff_ffff - idx) / modulus + 1;
        k = {$urandom, $urandom} % span;
        return HALF_W'(idx + k * modulus);
    endfunction

    // Presents one request, holds it until the block takes it, then records the expectation.
    task automatic send_request(input req_type_t req, input logic [HASH_W-1:0] hash,
                                input logic typed, input filter_result_t typed_result);
        filter_result_t predicted;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req_type <= req;
        key_hash <= hash;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = filter_update(req, hash);
        expected_results.push_back(typed ? typed_result : predicted);
        if (req == REQ_CLEAR)
            clear_pending = 1'b1;
    endtask

    // Waits until every result is in and the block has settled, clear sweep included.
    task automatic drain_requests();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (clear_pending)
            repeat (NUM_COUNTERS) @(posedge clk);
        clear_pending = 1'b0;
    endtask

    // Writes a register over the bus, then reads it back.
    task automatic register_write(input logic reg_idx, input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (reg_idx == REG_ACTIVE_SIZE)
            size_shadow = value[SIZE_W-1:0];
        else
            limit_shadow = value[LIMIT_W-1:0];
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (reg_idx == REG_ACTIVE_SIZE && prdata[SIZE_W-1:0] !== value[SIZE_W-1:0])
        begin
            $error("active_size: expected %0d, got %0d", value[SIZE_W-1:0], prdata[SIZE_W-1:0]);
            mismatch_count++;
        end
        if (reg_idx == REG_MAX_COUNT && prdata[LIMIT_W-1:0] !== value[LIMIT_W-1:0])
        begin
            $error("max_count: expected %0d, got %0d", value[LIMIT_W-1:0], prdata[LIMIT_W-1:0]);
            mismatch_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Result checker: every strobed result is matched against the oldest expectation.
    always @(posedge clk)
    begin
        filter_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (accepted !== want.accepted)
                begin
                    $error("accepted: expected %0d, got %0d", want.accepted, accepted);
                    mismatch_count++;
                end
                if (should_not_add !== want.should_not_add)
                begin
                    $error("should_not_add: expected %0d, got %0d",
                           want.should_not_add, should_not_add);
                    mismatch_count++;
                end
                if (hit_count !== want.hit_count)
                begin
                    $error("hit_count: expected %0d, got %0d", want.hit_count, hit_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either port for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // Stimulus: reset, directed table, then one randomised phase per register setting.
    initial
    begin
        int unsigned       modulus;
        int unsigned       idx_hi;
        int unsigned       idx_lo;
        int unsigned       pick;
        logic [APB_DATA_W-1:0] data;
        logic [HASH_W-1:0] hash;
        req_type_t         req;
        foreach (counter_model[i])
            counter_model[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests run on the reset register values with no idling.
        idle_pct = 0;
        for (int row = 0; row < DIRECTED_ROWS; row++)
            send_request(directed_rows[row].req, directed_rows[row].hash,
                         directed_rows[row].typed, directed_rows[row].result);
        drain_requests();

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            data = $urandom;
            data[SIZE_W-1:0] = phases[ph].size;
            register_write(REG_ACTIVE_SIZE, data);
            data = $urandom;
            data[LIMIT_W-1:0] = phases[ph].limit;
            register_write(REG_MAX_COUNT, data);
            idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 56 : 32);

            // A small pool of indices keeps the same counters busy so limits are reached.
            modulus = modulus_in_use();
            foreach (index_pool[i])
                index_pool[i] = $urandom_range(0, modulus - 1);

            for (int n = 0; n < phases[ph].items; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 1)
                    req = REQ_CLEAR;
                else if (pick < 1 + phases[ph].add_pct)
                    req = REQ_ADD;
                else if (pick < 1 + phases[ph].add_pct + phases[ph].remove_pct)
                    req = REQ_REMOVE;
                else
                    req = REQ_QUERY;
                if ($urandom_range(0, 99) < 30)
                    hash = {$urandom, $urandom};
                else
                begin
                    idx_hi = index_pool[$urandom_range(0, POOL_SIZE - 1)];
                    idx_lo = ($urandom_range(0, 3) == 0) ? idx_hi
                             : index_pool[$urandom_range(0, POOL_SIZE - 1)];
                    hash = {half_for_index(idx_hi, modulus), half_for_index(idx_lo, modulus)};
                end
                send_request(req, hash, 1'b0, '0);
            end
            drain_requests();
        end

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
